// ===== rtl/core/voltage_seven_segment_sequencer_defines.svh =====
// Assertion macros used by the sequencer core, vsss_seq.
`ifndef VOLTAGE_SEVEN_SEGMENT_SEQUENCER_DEFINES_SVH
`define VOLTAGE_SEVEN_SEGMENT_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
`define VSSS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vsss assertion failed");
`define VSSS_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("vsss forbidden condition seen");
`else
`define VSSS_ASSERT(lbl, clk, rst, prop)
`define VSSS_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

// ===== rtl/core/vsss_pkg.sv =====
// Shared types and constants of the voltage seven-segment sequencer.
package vsss_pkg;

   // Request kinds carried on req_tuser.
   localparam logic OP_TICK         = 1'b0;
   localparam logic OP_WRITE_RESULT = 1'b1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_CLAMP_MV      = 3'd0;
   localparam logic [2:0] CSR_REINIT_PERIOD = 3'd1;
   localparam logic [2:0] CSR_DECODE_MODE   = 3'd2;
   localparam logic [2:0] CSR_INTENSITY     = 3'd3;
   localparam logic [2:0] CSR_SCAN_LIMIT    = 3'd4;

   // Configuration reset values.
   localparam logic [13:0] CLAMP_MV_RESET      = 14'd5000;
   localparam logic [6:0]  REINIT_PERIOD_RESET = 7'd100;
   localparam logic [7:0]  DECODE_MODE_RESET   = 8'hFF;
   localparam logic [3:0]  INTENSITY_RESET     = 4'hF;
   localparam logic [2:0]  SCAN_LIMIT_RESET    = 3'h3;

   // Display controller registers and data.
   localparam logic [3:0] DREG_DECODE_MODE = 4'h9;
   localparam logic [3:0] DREG_INTENSITY   = 4'hA;
   localparam logic [3:0] DREG_SCAN_LIMIT  = 4'hB;
   localparam logic [3:0] DREG_SHUTDOWN    = 4'hC;
   localparam logic [7:0] SHUTDOWN_RUN     = 8'h01;
   localparam logic [7:0] POINT_BIT        = 8'h80;

   localparam logic [6:0] RUN_COUNT_MAX = 7'd127;

   // Reciprocals: x/100 = (x*5243)>>19 for x < 43690, y/10 = (y*205)>>11 for y < 1029.
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam logic [7:0]  RECIP_10  = 8'd205;

   typedef struct packed {
      logic [13:0] clamp_mv;
      logic [6:0]  reinit_period;
      logic [7:0]  decode_mode;
      logic [3:0]  intensity;
      logic [2:0]  scan_limit;
   } cfg_type;

   // One registered request: the reading is already clamped and split at 100.
   typedef struct packed {
      logic       op;
      logic       write_ok;
      logic [7:0] mv_hi;
      logic [6:0] mv_lo;
   } item_type;

   typedef struct packed {
      logic       write_valid;
      logic [3:0] write_reg;
      logic [7:0] write_val;
      logic       sequence_done;
      logic       sequence_failed;
      logic       needs_init;
   } result_type;

endpackage

// ===== rtl/core/vsss_seq.sv =====
// Sequencer state and write selection for the voltage seven-segment sequencer.
`include "voltage_seven_segment_sequencer_defines.svh"

module vsss_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  vsss_pkg::item_type   item,
   input  vsss_pkg::cfg_type    cfg,
   output logic                 result_valid,
   output vsss_pkg::result_type result
);

   logic       needs_init_ff, needs_init_in;
   logic [6:0] run_count_ff, run_count_in;
   logic       busy_ff, busy_in;
   logic       setup_ff, setup_in;
   logic [1:0] index_ff, index_in;
   logic [3:0][3:0] digits_ff, digits_in;

   logic [14:0] lo_prod;
   logic [15:0] hi_prod;
   logic [3:0]  lo_tens;
   logic [4:0]  hi_tens;
   logic [6:0]  lo_rest;
   logic [7:0]  hi_rest;
   logic [4:0]  thou_wide;
   logic [3:0][3:0] new_digits;

   logic [1:0]  issue_idx;
   logic        issue_setup;
   logic [3:0]  issue_digit;
   logic [3:0]  issue_reg;
   logic [7:0]  issue_val;
   logic [6:0]  run_next;

   // Second half of the decimal split: each half below 100 or 164 is cut at 10.
   always_comb begin
      lo_prod   = 15'(item.mv_lo) * 15'(vsss_pkg::RECIP_10);
      hi_prod   = 16'(item.mv_hi) * 16'(vsss_pkg::RECIP_10);
      lo_tens   = lo_prod[14:11];
      hi_tens   = hi_prod[15:11];
      lo_rest   = item.mv_lo - 7'(lo_tens) * 7'd10;
      hi_rest   = item.mv_hi - 8'(hi_tens) * 8'd10;
      thou_wide = (hi_tens >= 5'd10) ? hi_tens - 5'd10 : hi_tens;
      new_digits[0] = lo_rest[3:0];
      new_digits[1] = lo_tens;
      new_digits[2] = hi_rest[3:0];
      new_digits[3] = thou_wide[3:0];
   end

   always_comb begin
      run_next = (run_count_ff < vsss_pkg::RUN_COUNT_MAX) ? run_count_ff + 7'd1
                                                          : run_count_ff;
   end

   // Register write that the current position of the sequence issues.
   always_comb begin
      issue_idx   = (item.op == vsss_pkg::OP_TICK) ? 2'd0 : index_ff + 2'd1;
      issue_setup = (item.op == vsss_pkg::OP_TICK) ? needs_init_ff : setup_ff;
      issue_digit = (item.op == vsss_pkg::OP_TICK) ? new_digits[issue_idx]
                                                   : digits_ff[issue_idx];
      if (issue_setup) begin
         unique case (issue_idx)
            2'd0: begin
               issue_reg = vsss_pkg::DREG_DECODE_MODE;
               issue_val = cfg.decode_mode;
            end
            2'd1: begin
               issue_reg = vsss_pkg::DREG_INTENSITY;
               issue_val = {4'd0, cfg.intensity};
            end
            2'd2: begin
               issue_reg = vsss_pkg::DREG_SCAN_LIMIT;
               issue_val = {5'd0, cfg.scan_limit};
            end
            default: begin
               issue_reg = vsss_pkg::DREG_SHUTDOWN;
               issue_val = vsss_pkg::SHUTDOWN_RUN;
            end
         endcase
      end else begin
         issue_reg = {2'd0, issue_idx} + 4'd1;
         issue_val = {4'd0, issue_digit} |
                     ((issue_idx == 2'd3) ? vsss_pkg::POINT_BIT : 8'd0);
      end
   end

   always_comb begin
      needs_init_in = needs_init_ff;
      run_count_in  = run_count_ff;
      busy_in       = busy_ff;
      setup_in      = setup_ff;
      index_in      = index_ff;
      digits_in     = digits_ff;
      result_valid  = 1'b0;
      result        = '0;

      if (item.op == vsss_pkg::OP_TICK) begin
         // A tick that arrives during a running sequence is dropped.
         if (!busy_ff) begin
            busy_in      = 1'b1;
            index_in     = 2'd0;
            setup_in     = needs_init_ff;
            if (!needs_init_ff) begin
               digits_in = new_digits;
            end
            result_valid       = 1'b1;
            result.write_valid = 1'b1;
            result.write_reg   = issue_reg;
            result.write_val   = issue_val;
         end
      end else if (busy_ff) begin
         result_valid = 1'b1;
         if (!item.write_ok) begin
            busy_in       = 1'b0;
            needs_init_in = 1'b1;
            if (!setup_ff) begin
               run_count_in = run_next;
            end
            result.sequence_failed = 1'b1;
         end else if (index_ff == 2'd3) begin
            busy_in  = 1'b0;
            index_in = 2'd0;
            if (setup_ff) begin
               needs_init_in = 1'b0;
               run_count_in  = '0;
            end else begin
               run_count_in = run_next;
               if (run_next >= cfg.reinit_period) begin
                  needs_init_in = 1'b1;
               end
            end
            result.sequence_done = 1'b1;
         end else begin
            index_in           = index_ff + 2'd1;
            result.write_valid = 1'b1;
            result.write_reg   = issue_reg;
            result.write_val   = issue_val;
         end
      end
      result.needs_init = needs_init_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needs_init_ff <= 1'b1;
         run_count_ff  <= '0;
         busy_ff       <= 1'b0;
         setup_ff      <= 1'b0;
         index_ff      <= '0;
      end else if (step) begin
         needs_init_ff <= needs_init_in;
         run_count_ff  <= run_count_in;
         busy_ff       <= busy_in;
         setup_ff      <= setup_in;
         index_ff      <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         digits_ff <= digits_in;
      end
   end

   `VSSS_ASSERT(a_end_frees, clock, reset,
      step && result_valid && (result.sequence_done || result.sequence_failed) |=> !busy_ff)
   `VSSS_ASSERT(a_write_holds_busy, clock, reset,
      step && result_valid && result.write_valid |=> busy_ff)
   `VSSS_ASSERT(a_setup_done_clears, clock, reset,
      step && result.sequence_done && setup_ff |=> !needs_init_ff && run_count_ff == 7'd0)
   `VSSS_ASSERT_NEVER(a_write_and_end, clock, reset,
      result_valid && result.write_valid && (result.sequence_done || result.sequence_failed))

endmodule

// ===== rtl/core/voltage_seven_segment_sequencer.sv =====
// Top level of the voltage seven-segment sequencer: config, request and response registers.
// A request reaches the response port through the request register, then the response
// register; requests that cause no response vanish.
// Throughput: one request per cycle; the response register frees as it is taken,
// so the request side stalls only while a response waits on rsp_tready.
// Reset: synchronous and active high; the display starts in needs-init, config regs reload.

module voltage_seven_segment_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] voltage_mv, [16] write_ok, rest zero
   input  logic        req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] write_valid, [4:1] write_reg, [12:5] write_val,
                                    // [13] sequence_done, [14] sequence_failed, [15] needs_init
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [13:0] csr_wdata
);

   vsss_pkg::cfg_type    cfg_ff;
   vsss_pkg::item_type   item_ff, item_in;
   vsss_pkg::result_type rsp_ff;
   vsss_pkg::result_type seq_result;
   logic                 item_valid_ff;
   logic                 rsp_valid_ff;
   logic                 seq_result_valid;
   logic                 advance;
   logic                 step;
   logic                 req_fire;
   logic [13:0]          clamped;
   logic [26:0]          hi_prod;
   logic [7:0]           hi;
   logic [13:0]          lo_wide;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = item_valid_ff && advance;
   assign req_tready = !item_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // Clamp and first decimal cut at 100, ahead of the request register.
   always_comb begin
      clamped = (req_tdata[15:0] > {2'd0, cfg_ff.clamp_mv}) ? cfg_ff.clamp_mv
                                                             : req_tdata[13:0];
      hi_prod = 27'(clamped) * 27'(vsss_pkg::RECIP_100);
      hi      = hi_prod[26:19];
      lo_wide = clamped - 14'(hi) * 14'd100;
      item_in.op       = req_tuser;
      item_in.write_ok = req_tdata[16];
      item_in.mv_hi    = hi;
      item_in.mv_lo    = lo_wide[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clamp_mv      <= vsss_pkg::CLAMP_MV_RESET;
         cfg_ff.reinit_period <= vsss_pkg::REINIT_PERIOD_RESET;
         cfg_ff.decode_mode   <= vsss_pkg::DECODE_MODE_RESET;
         cfg_ff.intensity     <= vsss_pkg::INTENSITY_RESET;
         cfg_ff.scan_limit    <= vsss_pkg::SCAN_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            vsss_pkg::CSR_CLAMP_MV:      cfg_ff.clamp_mv      <= csr_wdata;
            vsss_pkg::CSR_REINIT_PERIOD: cfg_ff.reinit_period <= csr_wdata[6:0];
            vsss_pkg::CSR_DECODE_MODE:   cfg_ff.decode_mode   <= csr_wdata[7:0];
            vsss_pkg::CSR_INTENSITY:     cfg_ff.intensity     <= csr_wdata[3:0];
            vsss_pkg::CSR_SCAN_LIMIT:    cfg_ff.scan_limit    <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            item_valid_ff <= 1'b1;
         end else if (step) begin
            item_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= item_valid_ff && seq_result_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      if (step) begin
         rsp_ff <= seq_result;
      end
   end

   vsss_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item         (item_ff),
      .cfg          (cfg_ff),
      .result_valid (seq_result_valid),
      .result       (seq_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.needs_init, rsp_ff.sequence_failed, rsp_ff.sequence_done,
                        rsp_ff.write_val, rsp_ff.write_reg, rsp_ff.write_valid};

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the voltage seven-segment sequencer: directed and random requests.
`timescale 1ns / 1ps

module tb;
   import vsss_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 6;
   localparam logic [2:0] CSR_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] CSR_LAST_INDEX = 3'd7;
   localparam logic [1:0] LAST_WRITE = 2'd3;

   // Same bit order as rsp_tdata, needs_init in the top bit.
   typedef struct packed {
      logic       needs_init;
      logic       sequence_failed;
      logic       sequence_done;
      logic [7:0] write_val;
      logic [3:0] write_reg;
      logic       write_valid;
   } display_rsp_type;

   typedef enum {ROW_PREDICT, ROW_SILENT, ROW_TYPED} row_check_type;

   typedef struct {
      logic            op;
      logic [15:0]     mv;
      logic            ok;
      row_check_type   how;
      display_rsp_type rsp;
   } dir_row_type;

   typedef struct {
      cfg_type cfg;
      int      items;
      int      fail_pct;
      int      noise_pct;
      bit      quiet;
      bit      random_cfg;
   } phase_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [15:0] voltage_mv, [16] write_ok, rest zero
   logic        req_tuser = 1'b0; // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [0] write_valid, [4:1] write_reg, [12:5] write_val,
                                  // [13] sequence_done, [14] sequence_failed, [15] needs_init
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [13:0] csr_wdata = '0;

   voltage_seven_segment_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the configuration and of the sequencer state.
   cfg_type     shadow = '{CLAMP_MV_RESET, REINIT_PERIOD_RESET, DECODE_MODE_RESET,
                           INTENSITY_RESET, SCAN_LIMIT_RESET};
   logic        ni_flag = 1'b1;
   logic [6:0]  run_count = '0;
   logic        seq_busy = 1'b0;
   logic        seq_setup = 1'b0;
   logic [1:0]  wr_index = '0;
   logic [3:0]  digits [4];

   display_rsp_type pending_rsp [$];
   int              mismatches = 0;
   int              cycle_count = 0;
   bit              no_idle = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic display_rsp_type write_rsp(logic [3:0] wreg, logic [7:0] val, logic ni);
      display_rsp_type r;
      r = '0;
      r.write_valid = 1'b1;
      r.write_reg = wreg;
      r.write_val = val;
      r.needs_init = ni;
      return r;
   endfunction

   function automatic display_rsp_type status_rsp(logic done, logic aborted, logic ni);
      display_rsp_type r;
      r = '0;
      r.sequence_done = done;
      r.sequence_failed = aborted;
      r.needs_init = ni;
      return r;
   endfunction

   // The display write that the current sequence position calls for.
   function automatic display_rsp_type next_display_write();
      logic [3:0] wreg;
      logic [7:0] val;
      if (seq_setup) begin
         case (wr_index)
            2'd0: begin
               wreg = DREG_DECODE_MODE;
               val = shadow.decode_mode;
            end
            2'd1: begin
               wreg = DREG_INTENSITY;
               val = {4'b0, shadow.intensity};
            end
            2'd2: begin
               wreg = DREG_SCAN_LIMIT;
               val = {5'b0, shadow.scan_limit};
            end
            default: begin
               wreg = DREG_SHUTDOWN;
               val = SHUTDOWN_RUN;
            end
         endcase
      end else begin
         wreg = 4'(wr_index) + 4'd1;
         val = {4'b0, digits[wr_index]};
         if (wr_index == LAST_WRITE) val = val | POINT_BIT;
      end
      return write_rsp(wreg, val, ni_flag);
   endfunction

   function automatic void count_display_run();
      if (run_count != RUN_COUNT_MAX) run_count = run_count + 7'd1;
      if (run_count >= shadow.reinit_period) ni_flag = 1'b1;
   endfunction

   // Advances the sequencer state by one request; returns 1 if a response follows.
   function automatic bit sequencer_next(logic op, logic [15:0] mv, logic ok,
                                         output display_rsp_type r);
      int unsigned v;
      r = '0;
      if (op == OP_TICK) begin
         if (seq_busy) return 1'b0;
         seq_busy = 1'b1;
         wr_index = '0;
         if (ni_flag) begin
            seq_setup = 1'b1;
         end else begin
            seq_setup = 1'b0;
            v = (mv > shadow.clamp_mv) ? shadow.clamp_mv : mv;
            digits[0] = 4'(v % 10);
            digits[1] = 4'((v / 10) % 10);
            digits[2] = 4'((v / 100) % 10);
            digits[3] = 4'((v / 1000) % 10);
         end
         r = next_display_write();
         return 1'b1;
      end
      if (!seq_busy) return 1'b0;
      if (!ok) begin
         seq_busy = 1'b0;
         ni_flag = 1'b1;
         if (!seq_setup) count_display_run();
         r = status_rsp(1'b0, 1'b1, ni_flag);
         return 1'b1;
      end
      if (wr_index == LAST_WRITE) begin
         seq_busy = 1'b0;
         wr_index = '0;
         if (seq_setup) begin
            ni_flag = 1'b0;
            run_count = '0;
         end else begin
            count_display_run();
         end
         r = status_rsp(1'b1, 1'b0, ni_flag);
         return 1'b1;
      end
      wr_index = wr_index + 2'd1;
      r = next_display_write();
      return 1'b1;
   endfunction

   function automatic logic [15:0] pick_reading();
      int near;
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 9999));
         1: return 16'($urandom_range(0, 99));
         2: begin
            near = int'(shadow.clamp_mv) + int'($urandom_range(0, 2)) - 1;
            if (near < 0) near = 0;
            return 16'(near);
         end
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(string what, display_rsp_type want, display_rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $write("%s: expected wv=%0b reg=%0h val=%02h done=%0b abort=%0b ni=%0b",
                what, want.write_valid, want.write_reg, want.write_val,
                want.sequence_done, want.sequence_failed, want.needs_init);
         $display(", got wv=%0b reg=%0h val=%02h done=%0b abort=%0b ni=%0b",
                  got.write_valid, got.write_reg, got.write_val,
                  got.sequence_done, got.sequence_failed, got.needs_init);
      end
   endtask

   // Presents one request, waits for its handshake and records what it should cause.
   task automatic send_request(logic op, logic [15:0] mv, logic ok, row_check_type how,
                               display_rsp_type typed_rsp);
      int gap;
      display_rsp_type model_rsp;
      bit has_rsp;
      gap = no_idle ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'b0, ok, mv};
      do @(posedge clock); while (req_tready !== 1'b1);
      has_rsp = sequencer_next(op, mv, ok, model_rsp);
      if (how == ROW_TYPED) pending_rsp.push_back(typed_rsp);
      else if (how == ROW_PREDICT && has_rsp) pending_rsp.push_back(model_rsp);
   endtask

   // Lets every outstanding response drain, plus the pipeline depth for silent requests.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [13:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_CLAMP_MV:      shadow.clamp_mv = val;
         CSR_REINIT_PERIOD: shadow.reinit_period = val[6:0];
         CSR_DECODE_MODE:   shadow.decode_mode = val[7:0];
         CSR_INTENSITY:     shadow.intensity = val[3:0];
         CSR_SCAN_LIMIT:    shadow.scan_limit = val[2:0];
         default: ;
      endcase
   endtask

   // Narrow registers get random upper bits, which the block must drop.
   task automatic apply_config(cfg_type c);
      write_csr(CSR_CLAMP_MV, c.clamp_mv);
      write_csr(CSR_REINIT_PERIOD, {7'($urandom), c.reinit_period});
      write_csr(CSR_DECODE_MODE, {6'($urandom), c.decode_mode});
      write_csr(CSR_INTENSITY, {10'($urandom), c.intensity});
      write_csr(CSR_SCAN_LIMIT, {11'($urandom), c.scan_limit});
      for (int i = CSR_FIRST_UNUSED; i <= CSR_LAST_INDEX; i++)
         write_csr(3'(i), 14'($urandom));
      csr_we <= 1'b0;
   endtask

   // Response side: ready in bursts, with stalls of random length.
   initial begin
      int on_len;
      int off_len;
      forever begin
         on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
         rsp_tready <= 1'b1;
         repeat (on_len) @(posedge clock);
         off_len = no_idle ? 0 : pick_gap();
         if (off_len != 0) begin
            rsp_tready <= 1'b0;
            repeat (off_len) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      display_rsp_type got;
      display_rsp_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got = display_rsp_type'(rsp_tdata);
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", '0, got);
         end else begin
            want = pending_rsp.pop_front();
            if (got.write_valid !== want.write_valid || got.write_reg !== want.write_reg ||
                got.write_val !== want.write_val || got.sequence_done !== want.sequence_done ||
                got.sequence_failed !== want.sequence_failed ||
                got.needs_init !== want.needs_init)
               report_mismatch("response mismatch", want, got);
         end
      end
   end

   initial begin
      dir_row_type rows [28];
      phase_type   phases [7];
      phase_type   ph;
      rows = '{
         // Write result while idle is ignored.
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_SILENT, '0},
         // First tick after reset starts the set-up sequence.
         '{OP_TICK, 16'd0, 1'b0, ROW_TYPED,
           write_rsp(DREG_DECODE_MODE, DECODE_MODE_RESET, 1'b1)},
         // A tick during a sequence is dropped.
         '{OP_TICK, 16'hFFFF, 1'b0, ROW_SILENT, '0},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_TYPED,
           write_rsp(DREG_INTENSITY, {4'b0, INTENSITY_RESET}, 1'b1)},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_TYPED,
           write_rsp(DREG_SCAN_LIMIT, {5'b0, SCAN_LIMIT_RESET}, 1'b1)},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_TYPED,
           write_rsp(DREG_SHUTDOWN, SHUTDOWN_RUN, 1'b1)},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_TYPED, status_rsp(1'b1, 1'b0, 1'b0)},
         // Full-scale reading is clamped to 5000 mV.
         '{OP_TICK, 16'hFFFF, 1'b1, ROW_TYPED, write_rsp(4'd1, 8'd0, 1'b0)},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_TYPED, write_rsp(4'd2, 8'd0, 1'b0)},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_TYPED, write_rsp(4'd3, 8'd0, 1'b0)},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_TYPED, write_rsp(4'd4, POINT_BIT | 8'd5, 1'b0)},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_TYPED, status_rsp(1'b1, 1'b0, 1'b0)},
         // A failed display write aborts and forces set-up.
         '{OP_TICK, 16'd1234, 1'b1, ROW_PREDICT, '0},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_PREDICT, '0},
         '{OP_WRITE_RESULT, 16'hFFFF, 1'b0, ROW_TYPED, status_rsp(1'b0, 1'b1, 1'b1)},
         '{OP_WRITE_RESULT, 16'd0, 1'b0, ROW_SILENT, '0},
         // A failed set-up write leaves the display in needs-init.
         '{OP_TICK, 16'd0, 1'b0, ROW_TYPED,
           write_rsp(DREG_DECODE_MODE, DECODE_MODE_RESET, 1'b1)},
         '{OP_WRITE_RESULT, 16'd0, 1'b0, ROW_TYPED, status_rsp(1'b0, 1'b1, 1'b1)},
         '{OP_TICK, 16'd4999, 1'b0, ROW_PREDICT, '0},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_PREDICT, '0},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_PREDICT, '0},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_PREDICT, '0},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_PREDICT, '0},
         '{OP_TICK, 16'd4999, 1'b0, ROW_PREDICT, '0},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_PREDICT, '0},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_PREDICT, '0},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_PREDICT, '0},
         '{OP_WRITE_RESULT, 16'd0, 1'b1, ROW_PREDICT, '0}
      };

      // Clamp above the four-digit range and a period of zero come first.
      phases[0] = '{'{14'h3FFF, 7'd0, 8'h00, 4'h0, 3'h0}, 100, 10, 8, 1'b0, 1'b0};
      phases[1] = '{'{14'd0, 7'd1, 8'hFF, 4'hF, 3'h7}, 100, 10, 8, 1'b1, 1'b0};
      // No aborts here, so the run counter climbs all the way to the longest period.
      phases[2] = '{'{14'd9999, 7'd127, 8'h5A, 4'h6, 3'h2}, 700, 0, 0, 1'b0, 1'b0};
      for (int p = 3; p < 7; p++)
         phases[p] = '{'0, 90, 12, 10, p[0], 1'b1};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 28; i++)
         send_request(rows[i].op, rows[i].mv, rows[i].ok, rows[i].how, rows[i].rsp);
      settle();

      for (int p = 0; p < 7; p++) begin
         ph = phases[p];
         if (ph.random_cfg) begin
            ph.cfg.clamp_mv = ($urandom_range(0, 3) == 0) ? 14'($urandom)
                                                          : 14'($urandom_range(0, 9999));
            ph.cfg.reinit_period = 7'($urandom_range(0, 40));
            ph.cfg.decode_mode = 8'($urandom);
            ph.cfg.intensity = 4'($urandom);
            ph.cfg.scan_limit = 3'($urandom);
         end
         apply_config(ph.cfg);
         no_idle = ph.quiet;
         for (int n = 0; n < ph.items; n++) begin
            if ($urandom_range(0, 99) < ph.noise_pct)
               send_request(1'($urandom), 16'($urandom), 1'($urandom), ROW_PREDICT, '0);
            else if (!seq_busy)
               send_request(OP_TICK, pick_reading(), 1'($urandom), ROW_PREDICT, '0);
            else
               send_request(OP_WRITE_RESULT, 16'($urandom),
                            $urandom_range(0, 99) >= ph.fail_pct, ROW_PREDICT, '0);
         end
         settle();
      end

      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
